// ===== rtl/core/tqm_pkg.sv =====
`timescale 1ns / 1ps
// widths and constants of the tetrahedron quality pipeline
package tqm_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int NVERT = 4;
	localparam int NPAIR = 6;

	// edge vectors and their products
	localparam int EDGE_W = COORD_WIDTH + 1;
	localparam int SQ_W = 2 * EDGE_W;
	localparam int CRS_W = SQ_W + 1;
	localparam int CL_W = EDGE_W + 1;
	localparam int CH_W = CRS_W - CL_W;
	localparam int PL_W = EDGE_W + CL_W + 1;
	localparam int PH_W = EDGE_W + CH_W;
	localparam int DET_W = EDGE_W + CRS_W;
	localparam int MAG_W = DET_W - 1;

	// threshold register and result
	localparam int THR_W = 17;
	localparam int Q_W = 19;
	localparam int RT_W = 17;
	localparam int Q_MAX = 1 << RT_W;
	localparam int XQ_W = 2 * RT_W;

	// limb split of the wide squares and cube
	localparam int DL = 4;
	localparam int DLIMB_W = (MAG_W + DL - 1) / DL;
	localparam int DPP_W = 2 * DLIMB_W;
	localparam int MAGP_W = DL * DLIMB_W;
	localparam int DP_W = 2 * MAGP_W;
	localparam int D2_W = 2 * MAG_W;
	localparam int LL = 3;
	localparam int LLIMB_W = (SQ_W + LL - 1) / LL;
	localparam int LPP_W = 2 * LLIMB_W;
	localparam int LSQP_W = LL * LLIMB_W;
	localparam int LP_W = 2 * LSQP_W;
	localparam int L2_W = 2 * SQ_W;
	localparam int L2L = (L2_W + LLIMB_W - 1) / LLIMB_W;
	localparam int L2P_W = L2L * LLIMB_W;
	localparam int CP_W = (L2L + LL) * LLIMB_W;
	localparam int L3_W = 3 * SQ_W;
	localparam int R_W = L3_W + 1;
	localparam int SR_W = XQ_W + 1;

endpackage

// ===== rtl/core/tet_quality_metric.sv =====
`timescale 1ns / 1ps
// tetrahedron quality: normalized signed volume over longest edge cubed
//
// Takes one tetrahedron (twelve signed Q16.16 coordinates) per clock and returns quality =
// sqrt(2) * det / Lmax^3 in signed Q2.16, truncated toward zero and saturated at +-2.0, with
// an inverted flag (negative volume) and a degenerate flag (longest edge at or below
// min_edge_len, quality forced to 0). Throughput is one tetrahedron per clock. From input to
// result, the pipeline has 64 register stages: 12 of edge, determinant, square and cube
// arithmetic, 34 of a restoring divider (one quotient bit per stage), 17 of a restoring
// square root (one root bit per stage) and the output register. While the output holds a
// result that is not taken, the whole pipeline holds. min_edge_len is written through
// cfg_wr_en / cfg_wr_data and resets to 0.
module tet_quality_metric (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic        [tqm_pkg::THR_W-1:0]       cfg_wr_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [tqm_pkg::COORD_WIDTH-1:0] v0_x,
	input  logic signed [tqm_pkg::COORD_WIDTH-1:0] v0_y,
	input  logic signed [tqm_pkg::COORD_WIDTH-1:0] v0_z,
	input  logic signed [tqm_pkg::COORD_WIDTH-1:0] v1_x,
	input  logic signed [tqm_pkg::COORD_WIDTH-1:0] v1_y,
	input  logic signed [tqm_pkg::COORD_WIDTH-1:0] v1_z,
	input  logic signed [tqm_pkg::COORD_WIDTH-1:0] v2_x,
	input  logic signed [tqm_pkg::COORD_WIDTH-1:0] v2_y,
	input  logic signed [tqm_pkg::COORD_WIDTH-1:0] v2_z,
	input  logic signed [tqm_pkg::COORD_WIDTH-1:0] v3_x,
	input  logic signed [tqm_pkg::COORD_WIDTH-1:0] v3_y,
	input  logic signed [tqm_pkg::COORD_WIDTH-1:0] v3_z,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [tqm_pkg::Q_W-1:0]         quality,
	output logic                                   inverted,
	output logic                                   degenerate
);
	import tqm_pkg::*;

	localparam int DIV_N = XQ_W;
	localparam int PA [NPAIR] = '{0, 0, 0, 1, 1, 2};
	localparam int PB [NPAIR] = '{1, 2, 3, 2, 3, 3};

	logic adv;
	logic [THR_W-1:0] thr_q;
	logic [2*THR_W-1:0] thr_sq;
	logic signed [COORD_WIDTH-1:0] pt [3*NVERT];

	logic signed [EDGE_W-1:0] ed_d [NPAIR][3];
	logic v_s1;
	logic signed [EDGE_W-1:0] ed_s1 [NPAIR][3];
	logic v_s2;
	logic [SQ_W-1:0] esq_s2 [NPAIR][3];
	logic signed [SQ_W-1:0] xp_s2 [6];
	logic signed [EDGE_W-1:0] e1_s2 [3];
	logic v_s3;
	logic [SQ_W-1:0] lsq_s3 [NPAIR];
	logic signed [CRS_W-1:0] crs_s3 [3];
	logic signed [EDGE_W-1:0] e1_s3 [3];
	logic v_s4;
	logic signed [PL_W-1:0] pl_s4 [3];
	logic signed [PH_W-1:0] ph_s4 [3];
	logic [SQ_W-1:0] mx_s4 [3];
	logic signed [DET_W-1:0] det_d;
	logic [SQ_W-1:0] lmax_d;
	logic v_s5;
	logic signed [DET_W-1:0] det_s5;
	logic [SQ_W-1:0] lmax_s5;
	logic v_s6;
	logic [MAG_W-1:0] mag_s6;
	logic [SQ_W-1:0] lsq_s6;
	logic inv_s6, dgn_s6;
	logic [MAGP_W-1:0] mag_pad;
	logic [LSQP_W-1:0] lsq_pad6;
	logic v_s7;
	logic [DPP_W-1:0] dpp_s7 [DL][DL];
	logic [LPP_W-1:0] lpp_s7 [LL][LL];
	logic [SQ_W-1:0] lsq_s7;
	logic inv_s7, dgn_s7;
	logic [DP_W-1:0] drow_d [DL];
	logic [LP_W-1:0] lrow_d [LL];
	logic v_s8;
	logic [DP_W-1:0] drow_s8 [DL];
	logic [LP_W-1:0] lrow_s8 [LL];
	logic [SQ_W-1:0] lsq_s8;
	logic inv_s8, dgn_s8;
	logic [DP_W-1:0] d2_d;
	logic [LP_W-1:0] l2_d;
	logic v_s9;
	logic [D2_W-1:0] d2_s9;
	logic [L2_W-1:0] l2_s9;
	logic [SQ_W-1:0] lsq_s9;
	logic inv_s9, dgn_s9;
	logic [L2P_W-1:0] l2_pad;
	logic [LSQP_W-1:0] lsq_pad9;
	logic v_s10;
	logic [LPP_W-1:0] cpp_s10 [L2L][LL];
	logic [D2_W-1:0] d2_s10;
	logic inv_s10, dgn_s10;
	logic [CP_W-1:0] crow_d [L2L];
	logic v_s11;
	logic [CP_W-1:0] crow_s11 [L2L];
	logic [D2_W-1:0] d2_s11;
	logic inv_s11, dgn_s11;
	logic [CP_W-1:0] l3_d;
	logic v_s12;
	logic [L3_W-1:0] l3_s12;
	logic [D2_W-1:0] d2_s12;
	logic inv_s12, dgn_s12;

	// divider: stage 13 + i holds quotient step i
	logic [R_W-1:0] div_try [DIV_N];
	logic [R_W-1:0] div_dsr [DIV_N];
	logic [DIV_N-1:0] div_ge;
	logic div_sat0;
	logic [DIV_N-1:0] div_v_s13, div_sat_s13, div_inv_s13, div_dgn_s13;
	logic [L3_W-1:0] div_rem_s13 [DIV_N];
	logic [L3_W-1:0] div_l3_s13 [DIV_N];
	logic [XQ_W-1:0] div_quo_s13 [DIV_N];

	// square root: stage 47 + j holds root bit RT_W-1-j
	logic [SR_W-1:0] rt_rin [RT_W];
	logic [RT_W-1:0] rt_qin [RT_W];
	logic [SR_W-1:0] rt_trial [RT_W];
	logic [RT_W-1:0] rt_ok;
	logic [RT_W-1:0] rt_v_s47, rt_sat_s47, rt_inv_s47, rt_dgn_s47;
	logic [SR_W-1:0] rt_rem_s47 [RT_W];
	logic [RT_W-1:0] rt_root_s47 [RT_W];

	logic [RT_W:0] mag_fin;
	logic signed [Q_W-1:0] q_d;
	logic out_valid_q, inverted_q, degenerate_q;
	logic signed [Q_W-1:0] quality_q;

	assign adv = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign out_valid = out_valid_q;
	assign quality = quality_q;
	assign inverted = inverted_q;
	assign degenerate = degenerate_q;
	assign thr_sq = thr_q * thr_q;

	assign pt = '{v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z};

	always_comb begin
		for (int k = 0; k < NPAIR; k++) begin
			for (int c = 0; c < 3; c++) begin
				ed_d[k][c] = EDGE_W'(pt[PB[k]*3+c]) - EDGE_W'(pt[PA[k]*3+c]);
			end
		end
	end

	// determinant terms and longest squared edge
	always_comb begin
		det_d = '0;
		for (int c = 0; c < 3; c++) begin
			det_d = det_d + (DET_W'(ph_s4[c]) <<< CL_W) + DET_W'(pl_s4[c]);
		end
		lmax_d = (mx_s4[1] > mx_s4[2]) ? mx_s4[1] : mx_s4[2];
		lmax_d = (mx_s4[0] > lmax_d) ? mx_s4[0] : lmax_d;
	end

	assign mag_pad = MAGP_W'(mag_s6);
	assign lsq_pad6 = LSQP_W'(lsq_s6);
	assign l2_pad = L2P_W'(l2_s9);
	assign lsq_pad9 = LSQP_W'(lsq_s9);

	// partial-product row sums and final sums
	always_comb begin
		for (int i = 0; i < DL; i++) begin
			drow_d[i] = '0;
			for (int j = 0; j < DL; j++) begin
				drow_d[i] = drow_d[i] + (DP_W'(dpp_s7[i][j]) << (j*DLIMB_W));
			end
		end
		for (int i = 0; i < LL; i++) begin
			lrow_d[i] = '0;
			for (int j = 0; j < LL; j++) begin
				lrow_d[i] = lrow_d[i] + (LP_W'(lpp_s7[i][j]) << (j*LLIMB_W));
			end
		end
		d2_d = '0;
		for (int i = 0; i < DL; i++) begin
			d2_d = d2_d + (drow_s8[i] << (i*DLIMB_W));
		end
		l2_d = '0;
		for (int i = 0; i < LL; i++) begin
			l2_d = l2_d + (lrow_s8[i] << (i*LLIMB_W));
		end
		for (int i = 0; i < L2L; i++) begin
			crow_d[i] = '0;
			for (int j = 0; j < LL; j++) begin
				crow_d[i] = crow_d[i] + (CP_W'(cpp_s10[i][j]) << (j*LLIMB_W));
			end
		end
		l3_d = '0;
		for (int i = 0; i < L2L; i++) begin
			l3_d = l3_d + (crow_s11[i] << (i*LLIMB_W));
		end
	end

	// restoring division of d2 * 2^33 by l3, starting from d2 / 2 (saturates when not below l3)
	always_comb begin
		div_sat0 = L3_W'(d2_s12 >> 1) >= l3_s12;
		div_try[0] = {L3_W'(d2_s12 >> 1), d2_s12[0]};
		div_dsr[0] = {1'b0, l3_s12};
		for (int i = 1; i < DIV_N; i++) begin
			div_try[i] = {div_rem_s13[i-1], 1'b0};
			div_dsr[i] = {1'b0, div_l3_s13[i-1]};
		end
		for (int i = 0; i < DIV_N; i++) begin
			div_ge[i] = div_try[i] >= div_dsr[i];
		end
	end

	// restoring square root of the quotient, remainder kept as x - root^2
	always_comb begin
		rt_rin[0] = SR_W'(div_quo_s13[DIV_N-1]);
		rt_qin[0] = '0;
		for (int j = 1; j < RT_W; j++) begin
			rt_rin[j] = rt_rem_s47[j-1];
			rt_qin[j] = rt_root_s47[j-1];
		end
		for (int j = 0; j < RT_W; j++) begin
			rt_trial[j] = (SR_W'(rt_qin[j]) << (RT_W - j))
				+ (SR_W'(1) << (2*(RT_W - 1 - j)));
			rt_ok[j] = rt_trial[j] <= rt_rin[j];
		end
	end

	always_comb begin
		mag_fin = rt_sat_s47[RT_W-1] ? (RT_W+1)'(Q_MAX) : {1'b0, rt_root_s47[RT_W-1]};
		if (rt_dgn_s47[RT_W-1]) begin
			q_d = '0;
		end else if (rt_inv_s47[RT_W-1]) begin
			q_d = -$signed(Q_W'(mag_fin));
		end else begin
			q_d = $signed(Q_W'(mag_fin));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			div_v_s13 <= '0;
			rt_v_s47 <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (adv) begin
				v_s1 <= in_valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
				v_s6 <= v_s5;
				v_s7 <= v_s6;
				v_s8 <= v_s7;
				v_s9 <= v_s8;
				v_s10 <= v_s9;
				v_s11 <= v_s10;
				v_s12 <= v_s11;
				div_v_s13 <= {div_v_s13[DIV_N-2:0], v_s12};
				rt_v_s47 <= {rt_v_s47[RT_W-2:0], div_v_s13[DIV_N-1]};
				out_valid_q <= rt_v_s47[RT_W-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ed_s1 <= ed_d;

			for (int k = 0; k < NPAIR; k++) begin
				for (int c = 0; c < 3; c++) begin
					esq_s2[k][c] <= SQ_W'(ed_s1[k][c] * ed_s1[k][c]);
				end
			end
			xp_s2[0] <= SQ_W'(ed_s1[1][1] * ed_s1[2][2]);
			xp_s2[1] <= SQ_W'(ed_s1[1][2] * ed_s1[2][1]);
			xp_s2[2] <= SQ_W'(ed_s1[1][2] * ed_s1[2][0]);
			xp_s2[3] <= SQ_W'(ed_s1[1][0] * ed_s1[2][2]);
			xp_s2[4] <= SQ_W'(ed_s1[1][0] * ed_s1[2][1]);
			xp_s2[5] <= SQ_W'(ed_s1[1][1] * ed_s1[2][0]);
			e1_s2 <= ed_s1[0];

			for (int k = 0; k < NPAIR; k++) begin
				lsq_s3[k] <= esq_s2[k][0] + esq_s2[k][1] + esq_s2[k][2];
			end
			for (int c = 0; c < 3; c++) begin
				crs_s3[c] <= CRS_W'(xp_s2[2*c]) - CRS_W'(xp_s2[2*c+1]);
			end
			e1_s3 <= e1_s2;

			// cross component split into low unsigned and high signed halves
			for (int c = 0; c < 3; c++) begin
				pl_s4[c] <= PL_W'(e1_s3[c] * $signed({1'b0, crs_s3[c][CL_W-1:0]}));
				ph_s4[c] <= PH_W'(e1_s3[c] * $signed(crs_s3[c][CRS_W-1:CL_W]));
				mx_s4[c] <= (lsq_s3[2*c] > lsq_s3[2*c+1]) ? lsq_s3[2*c] : lsq_s3[2*c+1];
			end

			det_s5 <= det_d;
			lmax_s5 <= lmax_d;

			inv_s6 <= det_s5[DET_W-1];
			mag_s6 <= det_s5[DET_W-1] ? MAG_W'(-det_s5) : MAG_W'(det_s5);
			lsq_s6 <= lmax_s5;
			dgn_s6 <= lmax_s5 <= SQ_W'(thr_sq);

			for (int i = 0; i < DL; i++) begin
				for (int j = 0; j < DL; j++) begin
					dpp_s7[i][j] <= DPP_W'(mag_pad[i*DLIMB_W +: DLIMB_W]
						* mag_pad[j*DLIMB_W +: DLIMB_W]);
				end
			end
			for (int i = 0; i < LL; i++) begin
				for (int j = 0; j < LL; j++) begin
					lpp_s7[i][j] <= LPP_W'(lsq_pad6[i*LLIMB_W +: LLIMB_W]
						* lsq_pad6[j*LLIMB_W +: LLIMB_W]);
				end
			end
			lsq_s7 <= lsq_s6;
			inv_s7 <= inv_s6;
			dgn_s7 <= dgn_s6;

			drow_s8 <= drow_d;
			lrow_s8 <= lrow_d;
			lsq_s8 <= lsq_s7;
			inv_s8 <= inv_s7;
			dgn_s8 <= dgn_s7;

			d2_s9 <= D2_W'(d2_d);
			l2_s9 <= L2_W'(l2_d);
			lsq_s9 <= lsq_s8;
			inv_s9 <= inv_s8;
			dgn_s9 <= dgn_s8;

			for (int i = 0; i < L2L; i++) begin
				for (int j = 0; j < LL; j++) begin
					cpp_s10[i][j] <= LPP_W'(l2_pad[i*LLIMB_W +: LLIMB_W]
						* lsq_pad9[j*LLIMB_W +: LLIMB_W]);
				end
			end
			d2_s10 <= d2_s9;
			inv_s10 <= inv_s9;
			dgn_s10 <= dgn_s9;

			crow_s11 <= crow_d;
			d2_s11 <= d2_s10;
			inv_s11 <= inv_s10;
			dgn_s11 <= dgn_s10;

			l3_s12 <= L3_W'(l3_d);
			d2_s12 <= d2_s11;
			inv_s12 <= inv_s11;
			dgn_s12 <= dgn_s11;

			div_rem_s13[0] <= L3_W'(div_ge[0] ? div_try[0] - div_dsr[0] : div_try[0]);
			div_quo_s13[0] <= XQ_W'(div_ge[0]);
			div_l3_s13[0] <= l3_s12;
			div_sat_s13[0] <= div_sat0;
			div_inv_s13[0] <= inv_s12;
			div_dgn_s13[0] <= dgn_s12;
			for (int i = 1; i < DIV_N; i++) begin
				div_rem_s13[i] <= L3_W'(div_ge[i] ? div_try[i] - div_dsr[i] : div_try[i]);
				div_quo_s13[i] <= {div_quo_s13[i-1][XQ_W-2:0], div_ge[i]};
				div_l3_s13[i] <= div_l3_s13[i-1];
				div_sat_s13[i] <= div_sat_s13[i-1];
				div_inv_s13[i] <= div_inv_s13[i-1];
				div_dgn_s13[i] <= div_dgn_s13[i-1];
			end

			for (int j = 0; j < RT_W; j++) begin
				rt_rem_s47[j] <= rt_ok[j] ? rt_rin[j] - rt_trial[j] : rt_rin[j];
				rt_root_s47[j] <= rt_ok[j] ? (rt_qin[j] | (RT_W'(1) << (RT_W - 1 - j)))
					: rt_qin[j];
			end
			rt_sat_s47 <= {rt_sat_s47[RT_W-2:0], div_sat_s13[DIV_N-1]};
			rt_inv_s47 <= {rt_inv_s47[RT_W-2:0], div_inv_s13[DIV_N-1]};
			rt_dgn_s47 <= {rt_dgn_s47[RT_W-2:0], div_dgn_s13[DIV_N-1]};

			quality_q <= q_d;
			inverted_q <= rt_inv_s47[RT_W-1];
			degenerate_q <= rt_dgn_s47[RT_W-1];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && degenerate_q |-> quality_q == '0)
		else $error("degenerate transfer carries nonzero quality");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && quality_q != '0 |-> inverted_q == quality_q[Q_W-1])
		else $error("quality sign disagrees with inverted flag");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_v_s13[DIV_N-1] && !div_sat_s13[DIV_N-1] && !div_dgn_s13[DIV_N-1]
		|-> div_rem_s13[DIV_N-1] < div_l3_s13[DIV_N-1])
		else $error("division remainder not below divisor");

	assert property (@(posedge clk) disable iff (!arst_n)
		rt_v_s47[RT_W-1] |-> rt_rem_s47[RT_W-1] <= (SR_W'(rt_root_s47[RT_W-1]) << 1))
		else $error("square root remainder too large");

endmodule
